/* rtl/pic_pkg.sv */
package pic_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_ACK   = 2'd2,
    REQ_LINE  = 2'd3
  } req_type_t;

  localparam logic [1:0] PORT_CMD  = 2'd0;
  localparam logic [1:0] PORT_DATA = 2'd2;

  // command byte decode
  localparam int CMD_ICW1_BIT  = 4;
  localparam int CMD_OCW3_BIT  = 3;
  localparam int OCW3_RR_BIT   = 1;
  localparam int OCW3_RIS_BIT  = 0;
  localparam int ICW1_SNGL_BIT = 1;
  localparam int ICW1_IC4_BIT  = 0;

  localparam logic [2:0] EOI_SPECIFIC    = 3'b011;
  localparam logic [2:0] EOI_NONSPECIFIC = 3'b001;

  typedef enum logic [4:0] {
    INIT_IDLE = 5'b00001,
    INIT_ICW2 = 5'b00010,
    INIT_ICW3 = 5'b00100,
    INIT_ICW4 = 5'b01000,
    INIT_DONE = 5'b10000
  } init_step_t;

  typedef struct packed {
    req_type_t  req_type;
    logic [1:0] port;
    logic [7:0] wdata;
    logic [2:0] irq_line;
    logic       irq_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] vector;
    logic       int_pending;
  } out_item_t;

endpackage

/* rtl/pic_in_stage.sv */
module pic_in_stage
  import pic_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     stage_valid,
  output in_item_t stage_item
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

endmodule

/* rtl/pic_core.sv */
module pic_core
  import pic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  logic [7:0] request_bits, request_bits_next;
  logic [7:0] service_bits, service_bits_next;
  logic [7:0] mask_bits, mask_bits_next;
  logic [7:0] init_word1, init_word1_next;
  logic [7:0] vector_base, vector_base_next;
  init_step_t init_step, init_step_next;
  logic       read_service, read_service_next;

  logic [7:0] pend;
  logic [7:0] grant;
  logic [2:0] grant_idx;
  logic [7:0] eoi_bit;
  logic [7:0] line_bit;
  logic [7:0] rdata;
  logic [7:0] vec;
  init_step_t after_icw2;
  init_step_t after_icw3;

  assign pend     = request_bits & ~mask_bits;
  assign grant    = pend & (~pend + 8'd1);
  assign eoi_bit  = 8'd1 << item.wdata[2:0];
  assign line_bit = 8'd1 << item.irq_line;

  // lowest set bit wins
  always_comb begin
    grant_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (pend[i]) begin
        grant_idx = 3'(i);
      end
    end
  end

  assign after_icw3 = init_word1[ICW1_IC4_BIT] ? INIT_ICW4 : INIT_DONE;
  assign after_icw2 = init_word1[ICW1_SNGL_BIT] ? after_icw3 : INIT_ICW3;

  always_comb begin
    request_bits_next = request_bits;
    service_bits_next = service_bits;
    mask_bits_next    = mask_bits;
    init_word1_next   = init_word1;
    vector_base_next  = vector_base;
    init_step_next    = init_step;
    read_service_next = read_service;
    rdata             = 8'd0;
    vec               = 8'd0;

    case (item.req_type)
      REQ_READ: begin
        if (item.port == PORT_CMD) begin
          rdata = read_service ? service_bits : request_bits;
        end else if (item.port == PORT_DATA) begin
          rdata = mask_bits;
        end
      end
      REQ_WRITE: begin
        if (item.port == PORT_CMD) begin
          if (item.wdata[CMD_ICW1_BIT]) begin
            mask_bits_next    = 8'd0;
            init_word1_next   = item.wdata;
            init_step_next    = INIT_ICW2;
            read_service_next = 1'b0;
          end else if (!item.wdata[CMD_OCW3_BIT]) begin
            if (item.wdata[7:5] == EOI_SPECIFIC) begin
              request_bits_next = request_bits & ~eoi_bit;
              service_bits_next = service_bits & ~eoi_bit;
            end else if (item.wdata[7:5] == EOI_NONSPECIFIC) begin
              request_bits_next = request_bits & ~service_bits;
              service_bits_next = 8'd0;
            end
          end else if (item.wdata[OCW3_RR_BIT]) begin
            read_service_next = item.wdata[OCW3_RIS_BIT];
          end
        end else if (item.port == PORT_DATA) begin
          case (init_step)
            INIT_ICW2: begin
              vector_base_next = item.wdata;
              init_step_next   = after_icw2;
            end
            INIT_ICW3: init_step_next = after_icw3;
            INIT_ICW4: init_step_next = INIT_DONE;
            INIT_DONE: mask_bits_next = item.wdata;
            default: ;
          endcase
        end
      end
      REQ_ACK: begin
        if (|pend) begin
          request_bits_next = request_bits & ~grant;
          service_bits_next = service_bits | grant;
          vec               = vector_base + {5'd0, grant_idx};
        end
      end
      default: begin
        if (item.irq_level) begin
          request_bits_next = request_bits | line_bit;
        end
      end
    endcase
  end

  assign result.rdata       = rdata;
  assign result.vector      = vec;
  assign result.int_pending = |(request_bits_next & ~mask_bits_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      request_bits <= 8'd0;
      service_bits <= 8'd0;
      mask_bits    <= 8'd0;
      init_word1   <= 8'd0;
      vector_base  <= 8'd0;
      init_step    <= INIT_IDLE;
      read_service <= 1'b0;
    end else if (step) begin
      request_bits <= request_bits_next;
      service_bits <= service_bits_next;
      mask_bits    <= mask_bits_next;
      init_word1   <= init_word1_next;
      vector_base  <= vector_base_next;
      init_step    <= init_step_next;
      read_service <= read_service_next;
    end
  end

endmodule

/* rtl/priority_interrupt_controller_top.sv */
// flow: an accepted transaction moves from the input register to the output register
//   when the output stage can advance; one transaction per cycle while out_ready is held
//   high, through the input register, the register-update logic and the output register
// reset: synchronous rst clears request, service and mask registers, the stored
//   init bytes, the init sequence and read select, and empties both stages
module priority_interrupt_controller_top
  import pic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      advance;
  logic      stage_valid;
  in_item_t  stage_item;
  logic      step;
  out_item_t result;

  assign advance = !out_valid || out_ready;
  assign step    = stage_valid && advance;

  pic_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  pic_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (stage_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage empty");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed transaction did not reach output");

  a_vector_only_on_ack: assert property (@(posedge clk) disable iff (rst)
    (step && stage_item.req_type != REQ_ACK) |=> out_data.vector == 8'd0)
    else $error("nonzero vector on a non-acknowledge transaction");

  a_rdata_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (step && stage_item.req_type != REQ_READ) |=> out_data.rdata == 8'd0)
    else $error("nonzero read data on a non-read transaction");
`endif

endmodule

/* tb/pic_checker.sv */
`timescale 1ns / 100ps

module pic_checker
  import pic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        results_due
);

  logic [7:0] irr;
  logic [7:0] isr;
  logic [7:0] imr;
  logic [7:0] icw1_byte;
  logic [7:0] base_vec;
  init_step_t step;
  logic       sel_isr;

  out_item_t  result_q[$];

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  // applies one transaction to the shadow registers and returns the response
  function automatic out_item_t pic_next_result(input in_item_t it);
    out_item_t  r;
    logic [7:0] pend;
    logic [7:0] d;
    logic [2:0] grant;
    r     = '0;
    d     = it.wdata;
    grant = 3'd0;
    case (it.req_type)
      REQ_READ: begin
        if (it.port == PORT_CMD) r.rdata = sel_isr ? isr : irr;
        else if (it.port == PORT_DATA) r.rdata = imr;
      end
      REQ_WRITE: begin
        if (it.port == PORT_CMD) begin
          if (d[CMD_ICW1_BIT]) begin
            imr       = '0;
            icw1_byte = d;
            step      = INIT_ICW2;
            sel_isr   = 1'b0;
          end else if (!d[CMD_OCW3_BIT]) begin
            if (d[7:5] == EOI_SPECIFIC) begin
              irr[d[2:0]] = 1'b0;
              isr[d[2:0]] = 1'b0;
            end else if (d[7:5] == EOI_NONSPECIFIC) begin
              irr = irr & ~isr;
              isr = '0;
            end
          end else if (d[OCW3_RR_BIT]) begin
            sel_isr = d[OCW3_RIS_BIT];
          end
        end else if (it.port == PORT_DATA) begin
          case (step)
            INIT_ICW2: begin
              base_vec = d;
              if (!icw1_byte[ICW1_SNGL_BIT]) step = INIT_ICW3;
              else if (icw1_byte[ICW1_IC4_BIT]) step = INIT_ICW4;
              else step = INIT_DONE;
            end
            INIT_ICW3: begin
              if (icw1_byte[ICW1_IC4_BIT]) step = INIT_ICW4;
              else step = INIT_DONE;
            end
            INIT_ICW4: step = INIT_DONE;
            INIT_DONE: imr = d;
            default: ;
          endcase
        end
      end
      REQ_ACK: begin
        pend = irr & ~imr;
        // lowest level wins
        for (int i = 7; i >= 0; i--) if (pend[i]) grant = 3'(i);
        if (pend != '0) begin
          irr[grant] = 1'b0;
          isr[grant] = 1'b1;
          r.vector   = base_vec + {5'd0, grant};
        end
      end
      default: begin
        if (it.irq_level) irr[it.irq_line] = 1'b1;
      end
    endcase
    r.int_pending = |(irr & ~imr);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      irr       = '0;
      isr       = '0;
      imr       = '0;
      icw1_byte = '0;
      base_vec  = '0;
      step      = INIT_IDLE;
      sel_isr   = 1'b0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (out_data.rdata !== want.rdata) begin
            $display("%0t: rdata expected %h actual %h", $time, want.rdata, out_data.rdata);
            mismatches++;
          end
          if (out_data.vector !== want.vector) begin
            $display("%0t: vector expected %h actual %h", $time, want.vector,
                     out_data.vector);
            mismatches++;
          end
          if (out_data.int_pending !== want.int_pending) begin
            $display("%0t: int_pending expected %b actual %b", $time, want.int_pending,
                     out_data.int_pending);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) result_q.push_back(pic_next_result(in_data));
    end
    results_due = result_q.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import pic_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int        mismatches;
  int        results_due;
  int        cycle_count = 0;
  bit        no_gaps = 1'b0;
  bit        hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  priority_interrupt_controller_top DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  pic_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .results_due(results_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic offer(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // fields that the request type ignores get random values
  task automatic issue(input req_type_t rt, input logic [1:0] p, input logic [7:0] d,
                       input logic [2:0] ln, input logic lv);
    in_item_t it;
    it.req_type  = rt;
    it.port      = p;
    it.wdata     = d;
    it.irq_line  = ln;
    it.irq_level = lv;
    offer(it);
  endtask

  task automatic rd(input logic [1:0] p);
    issue(REQ_READ, p, 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  task automatic wr(input logic [1:0] p, input logic [7:0] d);
    issue(REQ_WRITE, p, d, 3'($urandom), 1'($urandom));
  endtask

  task automatic ack_req();
    issue(REQ_ACK, 2'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  task automatic raise(input logic [2:0] ln, input logic lv);
    issue(REQ_LINE, 2'($urandom), 8'($urandom), ln, lv);
  endtask

  task automatic init_seq(input logic [7:0] icw1, input logic [7:0] base,
                          input logic [7:0] mask);
    wr(PORT_CMD, icw1);
    wr(PORT_DATA, base);
    if (!icw1[ICW1_SNGL_BIT]) wr(PORT_DATA, 8'($urandom));
    if (icw1[ICW1_IC4_BIT]) wr(PORT_DATA, 8'($urandom));
    wr(PORT_DATA, mask);
  endtask

  task automatic rand_step();
    int         pick;
    logic [2:0] code;
    in_item_t   junk;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      raise(3'($urandom), $urandom_range(0, 3) != 0);
    end else if (pick < 50) begin
      ack_req();
    end else if (pick < 65) begin
      rd($urandom_range(0, 4) < 2 ? PORT_CMD : ($urandom_range(0, 2) != 0 ? PORT_DATA
                                                                         : 2'($urandom)));
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0: code = EOI_SPECIFIC;
        1: code = EOI_NONSPECIFIC;
        default: code = 3'($urandom);
      endcase
      wr(PORT_CMD, {code, 2'b00, 3'($urandom)});
    end else if (pick < 82) begin
      wr(PORT_CMD, {3'($urandom), 2'b01, 3'($urandom)});
    end else if (pick < 89) begin
      // half of the masks are sparse so requests still get through
      wr(PORT_DATA, $urandom_range(0, 1) ? 8'($urandom) & 8'($urandom) : 8'($urandom));
    end else if (pick < 93) begin
      init_seq(8'($urandom) | 8'h10, 8'($urandom), 8'($urandom) & 8'($urandom));
    end else begin
      junk = in_item_t'(16'($urandom));
      offer(junk);
    end
  endtask

  // receiver: random stall per transaction, one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset, before any init sequence
    rd(PORT_CMD);
    rd(2'd1);
    rd(PORT_DATA);
    rd(2'd3);
    ack_req();
    wr(PORT_DATA, 8'hA5);
    raise(3'd5, 1'b0);
    wr(2'd1, 8'hFF);
    wr(2'd3, 8'hFF);
    // single-mode sequence with icw4, base wraps past 8'hff
    init_seq(8'hFF, 8'hFF, 8'h00);
    raise(3'd7, 1'b1);
    raise(3'd0, 1'b1);
    rd(PORT_CMD);
    ack_req();
    ack_req();
    wr(PORT_CMD, 8'h0B);
    rd(PORT_CMD);
    wr(PORT_CMD, 8'h67);
    wr(PORT_CMD, 8'h20);
    wr(PORT_CMD, 8'hE0);
    wr(PORT_CMD, 8'h0A);
    // sequence through icw3, everything masked
    init_seq(8'h10, 8'h00, 8'hFF);
    raise(3'd3, 1'b1);
    ack_req();
    rd(PORT_DATA);
    wr(PORT_DATA, 8'h00);

    for (int chunk = 0; chunk < 6; chunk++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (chunk == 2) begin
        no_gaps  = 1'b1;
        hold_req = 1'b1;
      end
      repeat (100) rand_step();
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
